// File: rtl/core/npc_pkg.sv
// Shared constants and types for the nearest palette color block.
package npc_pkg;

    localparam int PALETTE_DEPTH_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 8;
    localparam int RGB_W    = 3 * CHAN_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int DIST_W   = 18;
    localparam int OIDX_W   = 4;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/core/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/nearest_palette_color.sv
// Nearest palette color: top level with scan sequencer and one distance unit.
// Append, clear and unused codes go straight to the finish state, where the result is
// registered once the output is free; the next input transfer waits until then.
// Query over N loaded entries: one entry read per cycle through the palette RAM port,
// then the drain and finish states register the result; the next transfer waits until
// the result is registered. Sync active-low reset empties the palette; RAM is kept.
module nearest_palette_color #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    input  logic [npc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] func
    input  logic [npc_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] best_index, [11:4] best_red, [19:12] best_green,
    // [27:20] best_blue, [45:28] best_distance, [47:46] zero
    output logic [npc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [npc_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CW    = npc_pkg::CHAN_W;

    npc_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]               r_count;
    logic [IDX_W-1:0]               r_addr;
    logic                           r_cmp_valid;
    logic [IDX_W-1:0]               r_cmp_idx;
    logic [npc_pkg::RGB_W-1:0]      r_query;
    logic [IDX_W-1:0]               r_best_idx;
    logic [npc_pkg::RGB_W-1:0]      r_best_rgb;
    logic [npc_pkg::DIST_W-1:0]     r_best_dist;
    logic [npc_pkg::STATUS_W-1:0]   r_best_status;
    logic                           r_out_valid;
    logic [npc_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [npc_pkg::STATUS_W-1:0]   r_out_status;

    logic                           in_xfer;
    logic                           out_free;
    logic                           full;
    logic                           last_issue;
    logic                           issue;
    logic                           ram_wr;
    logic [npc_pkg::RGB_W-1:0]      in_rgb;
    logic [npc_pkg::RGB_W-1:0]      rd_rgb;
    logic [npc_pkg::DIST_W-1:0]     cand_dist;
    logic                           take;

    // Palette entries are kept as {red, green, blue}
    assign in_rgb = {s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW], s_axis_tdata[3*CW-1:2*CW]};

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_out_valid || m_axis_tready;
    assign full       = (r_count >= CNT_W'(PALETTE_DEPTH));
    assign last_issue = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);
    assign ram_wr     = in_xfer && (s_axis_tuser == npc_pkg::FUNC_APPEND) && !full;

    npc_ram #(
        .WIDTH(npc_pkg::RGB_W),
        .DEPTH(PALETTE_DEPTH),
        .AW   (IDX_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr),
        .i_wr_addr(r_count[IDX_W-1:0]),
        .i_wr_data(in_rgb),
        .i_rd_en  (issue),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_rgb)
    );

    // Distance unit: three absolute differences, squared and summed
    always_comb begin
        logic [CW-1:0] dr, dg, db;
        logic [CW-1:0] qr, qg, qb, er, eg, eb;
        logic [npc_pkg::SQ_W-1:0] sr, sg, sb;
        qr = r_query[3*CW-1:2*CW];
        qg = r_query[2*CW-1:CW];
        qb = r_query[CW-1:0];
        er = rd_rgb[3*CW-1:2*CW];
        eg = rd_rgb[2*CW-1:CW];
        eb = rd_rgb[CW-1:0];
        dr = (qr > er) ? (qr - er) : (er - qr);
        dg = (qg > eg) ? (qg - eg) : (eg - qg);
        db = (qb > eb) ? (qb - eb) : (eb - qb);
        sr = npc_pkg::SQ_W'(dr) * npc_pkg::SQ_W'(dr);
        sg = npc_pkg::SQ_W'(dg) * npc_pkg::SQ_W'(dg);
        sb = npc_pkg::SQ_W'(db) * npc_pkg::SQ_W'(db);
        cand_dist = npc_pkg::DIST_W'(sr) + npc_pkg::DIST_W'(sg) + npc_pkg::DIST_W'(sb);
    end

    // First entry always wins; later ones only on a strictly smaller distance
    assign take = r_cmp_valid && ((r_cmp_idx == '0) || (cand_dist < r_best_dist));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == npc_pkg::FUNC_QUERY && r_count != '0) begin
                        n_state = npc_pkg::ST_SCAN;
                    end else begin
                        n_state = npc_pkg::ST_FINISH;
                    end
                end
            end
            npc_pkg::ST_SCAN: begin
                if (last_issue) begin
                    n_state = npc_pkg::ST_DRAIN;
                end
            end
            npc_pkg::ST_DRAIN: begin
                n_state = npc_pkg::ST_FINISH;
            end
            npc_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = npc_pkg::ST_IDLE;
                end
            end
            default: n_state = npc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        unique case (r_state)
            npc_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            npc_pkg::ST_SCAN:   issue = 1'b1;
            npc_pkg::ST_DRAIN,
            npc_pkg::ST_FINISH: begin
                s_axis_tready = 1'b0;
                issue         = 1'b0;
            end
            default: begin
                s_axis_tready = 1'b0;
                issue         = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npc_pkg::ST_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= issue;
            if (ram_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (in_xfer && s_axis_tuser == npc_pkg::FUNC_CLEAR) begin
                r_count <= '0;
            end
            if (r_state == npc_pkg::ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (in_xfer) begin
            r_query     <= in_rgb;
            r_addr      <= '0;
            r_best_idx  <= '0;
            r_best_rgb  <= '0;
            r_best_dist <= '0;
            case (s_axis_tuser)
                npc_pkg::FUNC_APPEND: r_best_status <= full ? npc_pkg::STATUS_FULL
                                                            : npc_pkg::STATUS_OK;
                npc_pkg::FUNC_QUERY:  r_best_status <= (r_count == '0) ? npc_pkg::STATUS_EMPTY
                                                                       : npc_pkg::STATUS_OK;
                default:              r_best_status <= npc_pkg::STATUS_OK;
            endcase
        end else begin
            if (issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (take) begin
                r_best_idx  <= r_cmp_idx;
                r_best_rgb  <= rd_rgb;
                r_best_dist <= cand_dist;
            end
        end
        if (r_state == npc_pkg::ST_FINISH && out_free) begin
            r_out_data   <= {2'b00, r_best_dist,
                             r_best_rgb[CW-1:0], r_best_rgb[2*CW-1:CW],
                             r_best_rgb[3*CW-1:2*CW], npc_pkg::OIDX_W'(r_best_idx)};
            r_out_status <= r_best_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule
